>>> src/pair_distance_histogram_defines.svh
// Assertion macros for the pair distance histogram.
`ifndef PAIR_DISTANCE_HISTOGRAM_DEFINES_SVH
`define PAIR_DISTANCE_HISTOGRAM_DEFINES_SVH
`ifndef SYNTHESIS
`define PDH_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PDH_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define PDH_ASSERT(label, clk, rstn, prop, msg)
`define PDH_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

>>> src/pdh_pkg.sv
package pdh_pkg;
  localparam int unsigned MaxParticlesDefault = 1024;
  localparam int unsigned MaxBinsDefault      = 64;
  localparam int unsigned CountMax            = 524287;

  typedef enum logic [2:0] {
    RegBoxXx = 3'd0, RegBoxXy = 3'd1, RegBoxXz = 3'd2, RegBoxYy = 3'd3,
    RegBoxYz = 3'd4, RegBoxZz = 3'd5, RegInvBw = 3'd6, RegBins = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [19:0] xx;
    logic signed [19:0] xy;
    logic signed [19:0] xz;
    logic [19:0] yy;
    logic signed [19:0] yz;
    logic [19:0] zz;
    logic [31:0] inv_bw_sq;
    logic [6:0]  nbins;
  } cfg_t;

  // Handshake between sequencer and distance pipeline.
  typedef struct packed {
    logic        valid;
    logic        flush;
  } pipe_ctl_t;
endpackage

>>> src/pdh_if.sv
interface pdh_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frac_x;
  logic [15:0] frac_y;
  logic [15:0] frac_z;
  logic        last_particle;
  modport source (output valid, frac_x, frac_y, frac_z, last_particle, input ready);
  modport sink   (input valid, frac_x, frac_y, frac_z, last_particle, output ready);
endinterface

interface pdh_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  bin_number;
  logic [18:0] pair_count;
  logic        last_bin;
  modport source (output valid, bin_number, pair_count, last_bin, input ready);
  modport sink   (input valid, bin_number, pair_count, last_bin, output ready);
endinterface

interface pdh_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/pdh_isqrt.sv
// Bin index of q by a compare against k*k for k below the bin count; result is
// the largest k with k*k <= q, or invalid when q >= nb*nb. Two stages.
module pdh_isqrt #(
  parameter int unsigned MaxBins = pdh_pkg::MaxBinsDefault,
  localparam int unsigned BW = (MaxBins > 1) ? $clog2(MaxBins) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [63:0]   q_i,
  input  logic [6:0]    nb_i,
  output logic          valid_o,
  output logic          hit_o,
  output logic [BW-1:0] bin_o
);
  logic [MaxBins-1:0] ge_q;
  logic               ge_top_q;
  logic               v_q;
  logic [6:0]         nb_q;
  logic [MaxBins-1:0] ge_d;
  logic               hit_d;
  logic [BW-1:0]      bin_d;

  always_comb begin
    for (int k = 0; k < MaxBins; k++) begin
      ge_d[k] = (q_i >= 64'(k * k));
    end
  end

  always_comb begin
    hit_d = 1'b0;
    bin_d = '0;
    for (int k = 0; k < MaxBins; k++) begin
      if (ge_q[k] && (7'(k) < nb_q)) begin
        bin_d = BW'(k);
      end
    end
    // q below nb*nb means k=nb is not reached; k<=nb-1 holds for chosen bin
    hit_d = 1'b1;
    if (nb_q < 7'(MaxBins + 1) && nb_q != 0) begin
      if (ge_q[MaxBins-1] && (7'(MaxBins) == nb_q)) hit_d = !ge_top_q;
      else if (nb_q < 7'(MaxBins)) hit_d = !ge_q[nb_q[BW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v_q     <= valid_i;
      valid_o <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ge_q     <= ge_d;
    ge_top_q <= (q_i >= 64'(MaxBins * MaxBins));
    nb_q     <= nb_i;
    hit_o    <= hit_d;
    bin_o    <= bin_d;
  end
endmodule

>>> src/pdh_dist.sv
// Distance pipeline: wrap, matrix product, round and square, scale to q.
module pdh_dist (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [47:0]  pa_i,
  input  logic [47:0]  pb_i,
  input  pdh_pkg::cfg_t cfg_i,
  output logic         valid_o,
  output logic [63:0]  q_o
);
  logic [3:0] v_q;
  logic signed [15:0] sx_q, sy_q, sz_q;
  logic signed [37:0] p_xx_q, p_xy_q, p_xz_q, p_yy_q, p_yz_q, p_zz_q;
  logic signed [39:0] dx_q, dy_q, dz_q;
  logic [47:0] rsq_q;
  logic [63:0] phi_q, plo_q;

  function automatic logic [47:0] rsq1(input logic signed [39:0] v);
    logic [39:0] mag;
    logic [23:0] r;
    mag = v[39] ? 40'(-v) : 40'(v);
    r = 24'((mag + 40'd32768) >> 16);
    return 48'(r) * 48'(r);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else begin
      v_q     <= {v_q[2:0], valid_i};
      valid_o <= v_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q   <= signed'(pb_i[47:32] - pa_i[47:32]);
    sy_q   <= signed'(pb_i[31:16] - pa_i[31:16]);
    sz_q   <= signed'(pb_i[15:0] - pa_i[15:0]);
    p_xx_q <= 38'(sx_q) * 38'(signed'({1'b0, cfg_i.xx}));
    p_xy_q <= 38'(sy_q) * 38'(cfg_i.xy);
    p_xz_q <= 38'(sz_q) * 38'(cfg_i.xz);
    p_yy_q <= 38'(sy_q) * 38'(signed'({1'b0, cfg_i.yy}));
    p_yz_q <= 38'(sz_q) * 38'(cfg_i.yz);
    p_zz_q <= 38'(sz_q) * 38'(signed'({1'b0, cfg_i.zz}));
    dx_q   <= 40'(p_xx_q) + 40'(p_xy_q) + 40'(p_xz_q);
    dy_q   <= 40'(p_yy_q) + 40'(p_yz_q);
    dz_q   <= 40'(p_zz_q);
    rsq_q  <= rsq1(dx_q) + rsq1(dy_q) + rsq1(dz_q);
    phi_q  <= 64'(rsq_q) * 64'(cfg_i.inv_bw_sq[31:16]);
    plo_q  <= 64'(rsq_q) * 64'(cfg_i.inv_bw_sq[15:0]);
  end

  assign q_o = (phi_q + (plo_q >> 16)) >> 16;
  // valid_o aligns with phi_q: v_q and valid_o track the register stages sx_q, p_*_q, d*_q, rsq_q and phi_q.
endmodule

>>> src/pair_distance_histogram.sv
// Pair distance histogram.
// Input channel in_if: one beat per particle (frac_x/y/z); last_particle on the
// final beat of a frame starts the all-pairs pass over the stored positions.
// Beats beyond capacity are dropped but a last flag still starts the pass.
// Output channel out_if: one beat per active bin, bin_number ascending,
// last_bin on the final one. Configuration channel cfg_if writes registers
// by index; the user must write only while the block is idle (unchecked).
// Throughput: load beats are taken one per cycle in the load state. The pass
// visits one pair per cycle from the position memory (no pairs with fewer
// than two particles), then waits while the distance pipeline drains, then
// reads out and clears the histogram memory for each active bin. The pair loop
// and the single read port of each position memory copy set the pair rate.
// Reset clears the particle count and sets the registers to their defaults,
// then a pass over all MaxBins bins zeroes the histogram memory with the input
// held off; the position memory needs no clearing. A stalled receiver holds
// the output beat and the readout simply waits; no counts are lost.
`include "pair_distance_histogram_defines.svh"
module pair_distance_histogram #(
  parameter int unsigned MaxParticles = pdh_pkg::MaxParticlesDefault,
  parameter int unsigned MaxBins      = pdh_pkg::MaxBinsDefault,
  localparam int unsigned AW = $clog2(MaxParticles),
  localparam int unsigned CW = $clog2(MaxParticles + 1),
  localparam int unsigned BW = (MaxBins > 1) ? $clog2(MaxBins) : 1
) (
  input logic clk_i,
  input logic rst_ni,
  pdh_in_if.sink    in_if,
  pdh_out_if.source out_if,
  pdh_cfg_if.sink   cfg_if
);
  typedef enum logic [5:0] {
    StLoad  = 6'b000001, StPair = 6'b000010, StDrain = 6'b000100,
    StRead  = 6'b001000, StEmit = 6'b010000, StClear = 6'b100000
  } state_e;

  state_e state_q, state_d;
  pdh_pkg::cfg_t cfg_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] i_q, j_q;
  logic [3:0]    drain_q;
  logic [6:0]    nb;

  // Two copies of the position memory give two read ports.
  logic [47:0] mem_a [MaxParticles];
  logic [47:0] mem_b [MaxParticles];
  logic [47:0] rd_a_q, rd_b_q;
  logic        rd_v_q;
  logic [19:0] hist [MaxBins];

  always_comb begin
    if (cfg_q.nbins == 0) nb = 7'd1;
    else if (cfg_q.nbins > 7'(MaxBins)) nb = 7'(MaxBins);
    else nb = cfg_q.nbins;
  end

  assign in_if.ready  = (state_q == StLoad);
  assign cfg_if.ready = 1'b1;
  wire in_acc = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{xx: 20'd2560, xy: '0, xz: '0, yy: 20'd2560, yz: '0,
                 zz: 20'd2560, inv_bw_sq: 32'd65536, nbins: 7'd64};
    end else if (cfg_if.valid) begin
      case (pdh_pkg::reg_idx_e'(cfg_if.index))
        pdh_pkg::RegBoxXx: cfg_q.xx <= cfg_if.data[19:0];
        pdh_pkg::RegBoxXy: cfg_q.xy <= cfg_if.data[19:0];
        pdh_pkg::RegBoxXz: cfg_q.xz <= cfg_if.data[19:0];
        pdh_pkg::RegBoxYy: cfg_q.yy <= cfg_if.data[19:0];
        pdh_pkg::RegBoxYz: cfg_q.yz <= cfg_if.data[19:0];
        pdh_pkg::RegBoxZz: cfg_q.zz <= cfg_if.data[19:0];
        pdh_pkg::RegInvBw: cfg_q.inv_bw_sq <= cfg_if.data;
        pdh_pkg::RegBins:  cfg_q.nbins <= cfg_if.data[6:0];
        default: ;
      endcase
    end
  end

  // Pair sequencer.
  wire pair_go = (state_q == StPair) && (cnt_q > 1);
  wire [AW-1:0] last_idx = AW'(cnt_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (in_acc && cnt_q < CW'(MaxParticles)) begin
      mem_a[AW'(cnt_q)] <= {in_if.frac_x, in_if.frac_y, in_if.frac_z};
      mem_b[AW'(cnt_q)] <= {in_if.frac_x, in_if.frac_y, in_if.frac_z};
    end
    rd_a_q <= mem_a[i_q];
    rd_b_q <= mem_b[j_q];
  end

  logic          dist_v, hit_v, hit, upd_v;
  logic [63:0]   q;
  logic [BW-1:0] bin, upd_bin, emit_bin_q;
  logic [19:0]   hist_rd_q;
  logic          out_v_q;
  logic [18:0]   out_cnt_q;
  logic [5:0]    out_bin_q;
  logic          out_last_q;

  pdh_dist u_dist (
    .clk_i, .rst_ni, .valid_i(rd_v_q), .pa_i(rd_a_q), .pb_i(rd_b_q),
    .cfg_i(cfg_q), .valid_o(dist_v), .q_o(q)
  );

  pdh_isqrt #(.MaxBins(MaxBins)) u_isqrt (
    .clk_i, .rst_ni, .valid_i(dist_v), .q_i(q), .nb_i(nb),
    .valid_o(hit_v), .hit_o(hit), .bin_o(bin)
  );

  // Histogram read-modify-write: read bin, then increment next cycle with
  // forwarding when consecutive pairs hit the same bin.
  logic [19:0] hist_cur;
  logic        prev_w_q;
  logic [BW-1:0] prev_bin_q;
  logic [19:0] prev_val_q;
  assign upd_v = hit_v && hit;
  assign upd_bin = bin;

  logic        rmw_v_q;
  logic [BW-1:0] rmw_bin_q;
  logic [19:0] new_val;
  assign hist_cur = (prev_w_q && prev_bin_q == rmw_bin_q) ? prev_val_q : hist_rd_q;
  assign new_val  = (hist_cur < 20'(pdh_pkg::CountMax)) ? hist_cur + 1'b1 : hist_cur;

  wire emit_take = out_v_q && out_if.ready;
  // The clearing pass after reset and the readout both zero the addressed bin.
  wire hist_clr  = (state_q == StClear) || (state_q == StRead);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      cnt_q    <= '0;
      i_q      <= '0;
      j_q      <= '0;
      rd_v_q   <= 1'b0;
      rmw_v_q  <= 1'b0;
      prev_w_q <= 1'b0;
      drain_q  <= '0;
      out_v_q  <= 1'b0;
      emit_bin_q <= '0;
    end else begin
      rd_v_q   <= 1'b0;
      rmw_v_q  <= upd_v;
      prev_w_q <= rmw_v_q;
      state_q <= state_d;
      case (state_q)
        StClear: begin
          if (emit_bin_q == BW'(MaxBins - 1)) emit_bin_q <= '0;
          else emit_bin_q <= emit_bin_q + 1'b1;
        end
        StLoad: begin
          if (in_acc) begin
            if (cnt_q < CW'(MaxParticles)) cnt_q <= cnt_q + 1'b1;
            i_q <= '0;
            j_q <= AW'(1);
          end
        end
        StPair: begin
          if (pair_go) begin
            rd_v_q <= 1'b1;
            if (j_q == last_idx) begin
              i_q <= i_q + 1'b1;
              j_q <= i_q + AW'(2);
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
          drain_q <= '0;
        end
        StDrain: drain_q <= drain_q + 1'b1;
        StRead: begin
          out_v_q    <= 1'b1;
          out_bin_q  <= 6'(emit_bin_q);
          out_last_q <= (7'(emit_bin_q) + 7'd1 == nb);
        end
        StEmit: begin
          if (emit_take) begin
            out_v_q <= 1'b0;
            if (out_last_q) begin
              emit_bin_q <= '0;
              cnt_q      <= '0;
            end else begin
              emit_bin_q <= emit_bin_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rmw_v_q) begin
      hist[rmw_bin_q] <= new_val;
    end else if (hist_clr) begin
      hist[emit_bin_q] <= '0;
    end
    if (state_q == StRead) out_cnt_q <= hist[emit_bin_q][18:0];
    hist_rd_q  <= hist[upd_bin];
    rmw_bin_q  <= upd_bin;
    prev_bin_q <= rmw_bin_q;
    prev_val_q <= new_val;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (emit_bin_q == BW'(MaxBins - 1)) state_d = StLoad;
      StLoad:  if (in_acc && in_if.last_particle) state_d = StPair;
      StPair:  if (!pair_go || (j_q == last_idx && i_q + 1'b1 == last_idx))
                 state_d = StDrain;
      StDrain: if (drain_q == 4'd12) state_d = StRead;
      StRead:  state_d = StEmit;
      StEmit:  if (emit_take) state_d = out_last_q ? StLoad : StRead;
      default: state_d = StLoad;
    endcase
  end

  assign out_if.valid      = out_v_q;
  assign out_if.bin_number = out_bin_q;
  assign out_if.pair_count = out_cnt_q;
  assign out_if.last_bin   = out_last_q;

  `PDH_ASSERT(a_no_load_in_pass, clk_i, rst_ni, (state_q != StLoad) |-> !in_if.ready, "ready outside load")
  `PDH_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_v_q && !out_if.ready, out_v_q && $stable(out_bin_q), "output beat dropped")
  `PDH_ASSERT(a_no_out_in_pass, clk_i, rst_ni, (state_q == StPair || state_q == StLoad) |-> !out_v_q, "output during pass")
endmodule

>>> tb/tb_pair_distance_histogram.sv
`timescale 1ns / 1ps
module tb_pair_distance_histogram;
  localparam int unsigned NumParticles = 1024;
  localparam int unsigned NumBins      = 64;
  localparam int unsigned ItemTarget   = 170;
  localparam int unsigned LongHold     = 400;
  // Idle cycles without any beat before the run is declared hung. The longest
  // quiet stretch is the receiver's long hold-off (LongHold).
  localparam int unsigned IdleLimit    = 5000;

  logic clk_i;
  logic rst_ni;

  pdh_in_if  in_if ();
  pdh_out_if out_if ();
  pdh_cfg_if cfg_if ();

  pair_distance_histogram uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // One pending particle beat.
  typedef struct packed {
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] fz;
    logic        last;
  } particle_t;

  // One expected bin beat.
  typedef struct packed {
    logic [5:0]  bin;
    logic [18:0] count;
    logic        last;
  } bin_beat_t;

  particle_t particle_queue[$];
  bin_beat_t bins_expected[$];

  // The predictor's own copy of the block's state and registers.
  logic [15:0] store_x[NumParticles];
  logic [15:0] store_y[NumParticles];
  logic [15:0] store_z[NumParticles];
  int unsigned stored_n;
  int unsigned hist[NumBins];
  pdh_pkg::cfg_t shadow_cfg;

  int unsigned errors;
  int unsigned frames_done;
  int unsigned bins_seen;
  int unsigned particles_sent;
  int unsigned holds_asked;
  int unsigned holds_served;
  int unsigned hold_left;
  bit          hold_source;
  bit          in_taken;
  int unsigned idle_cycles;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint signed wrapped(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = b - a;
    return longint'($signed(d));
  endfunction

  function automatic longint unsigned rounded_square(input longint signed v);
    longint unsigned mag;
    longint unsigned r;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    r = (mag + 64'd32768) >> 16;
    return r * r;
  endfunction

  function automatic int unsigned bins_active();
    if (shadow_cfg.nbins == 0) return 1;
    if (shadow_cfg.nbins > NumBins) return NumBins;
    return 32'(shadow_cfg.nbins);
  endfunction

  // Stores one particle and, on the frame's last beat, runs the all-pairs
  // pass and queues one expected beat per active bin.
  task automatic predict_particle(input particle_t p);
    int unsigned nb;
    longint unsigned lim, hi, lo, rsq, q;
    longint signed sx, sy, sz, dx, dy, dz;
    int unsigned b;
    bin_beat_t e;
    if (stored_n < NumParticles) begin
      store_x[stored_n] = p.fx;
      store_y[stored_n] = p.fy;
      store_z[stored_n] = p.fz;
      stored_n++;
    end
    if (!p.last) return;
    nb = bins_active();
    lim = longint'(nb) * nb;
    hi = 64'(shadow_cfg.inv_bw_sq[31:16]);
    lo = 64'(shadow_cfg.inv_bw_sq[15:0]);
    for (int unsigned i = 0; i < stored_n; i++) begin
      for (int unsigned j = i + 1; j < stored_n; j++) begin
        sx = wrapped(store_x[i], store_x[j]);
        sy = wrapped(store_y[i], store_y[j]);
        sz = wrapped(store_z[i], store_z[j]);
        dx = sx * longint'({1'b0, shadow_cfg.xx}) + sy * longint'(shadow_cfg.xy)
           + sz * longint'(shadow_cfg.xz);
        dy = sy * longint'({1'b0, shadow_cfg.yy}) + sz * longint'(shadow_cfg.yz);
        dz = sz * longint'({1'b0, shadow_cfg.zz});
        rsq = rounded_square(dx) + rounded_square(dy) + rounded_square(dz);
        q = (rsq * hi + ((rsq * lo) >> 16)) >> 16;
        if (q < lim) begin
          b = 0;
          while (longint'(b + 1) * (b + 1) <= q) b++;
          if (hist[b] < pdh_pkg::CountMax) hist[b]++;
        end
      end
    end
    for (int unsigned k = 0; k < nb; k++) begin
      e.bin = k[5:0];
      e.count = hist[k][18:0];
      e.last = (k + 1 == nb);
      bins_expected = {bins_expected, e};
      hist[k] = 0;
    end
    stored_n = 0;
  endtask

  // Driver: bursts of beats with random gaps, changed at the falling edge.
  int unsigned burst_left;
  int unsigned gap_left;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        // The beat was taken at the last rising edge.
        predict_particle(particle_queue.pop_front());
        particles_sent++;
      end
      if (in_if.valid && !in_taken) begin
        // Hold the offered beat until it is taken.
      end else if (hold_source || particle_queue.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid         <= 1'b1;
        in_if.frac_x        <= particle_queue[0].fx;
        in_if.frac_y        <= particle_queue[0].fy;
        in_if.frac_z        <= particle_queue[0].fz;
        in_if.last_particle <= particle_queue[0].last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off counted here on request.
  int unsigned stall_phase;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LongHold;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      stall_phase++;
      if ((stall_phase % 64) < 16) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Monitor: sample output beats at the rising edge.
  bin_beat_t want;
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        bins_seen++;
        if (bins_expected.size() == 0) begin
          report_mismatch("unexpected bin beat", longint'(out_if.bin_number), -1);
        end else begin
          want = bins_expected.pop_front();
          if (out_if.bin_number !== want.bin)
            report_mismatch("bin_number", longint'(out_if.bin_number), longint'(want.bin));
          if (out_if.pair_count !== want.count)
            report_mismatch("pair_count", longint'(out_if.pair_count),
                            longint'(want.count));
          if (out_if.last_bin !== want.last)
            report_mismatch("last_bin", longint'(out_if.last_bin), longint'(want.last));
          if (want.last) frames_done++;
        end
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)
          || (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("Timeout: no beat for %0d cycles", idle_cycles);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Writes one register through the configuration channel and its shadow.
  task automatic write_reg(input pdh_pkg::reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      pdh_pkg::RegBoxXx: shadow_cfg.xx = value[19:0];
      pdh_pkg::RegBoxXy: shadow_cfg.xy = value[19:0];
      pdh_pkg::RegBoxXz: shadow_cfg.xz = value[19:0];
      pdh_pkg::RegBoxYy: shadow_cfg.yy = value[19:0];
      pdh_pkg::RegBoxYz: shadow_cfg.yz = value[19:0];
      pdh_pkg::RegBoxZz: shadow_cfg.zz = value[19:0];
      pdh_pkg::RegInvBw: shadow_cfg.inv_bw_sq = value;
      pdh_pkg::RegBins:  shadow_cfg.nbins = value[6:0];
      default: ;
    endcase
  endtask

  // Waits until every queued particle is taken and every bin has arrived,
  // then gives the pipeline a little time to settle.
  task automatic drain();
    while (particle_queue.size() != 0 || in_if.valid || bins_expected.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic add_particle(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input bit last);
    particle_t p;
    p.fx = x;
    p.fy = y;
    p.fz = z;
    p.last = last;
    particle_queue = {particle_queue, p};
  endtask

  // Queues a frame of n particles; clustered frames land in the low bins.
  task automatic add_frame(input int unsigned n, input bit clustered);
    logic [15:0] bx, by, bz;
    bx = 16'($urandom);
    by = 16'($urandom);
    bz = 16'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      if (clustered)
        add_particle(16'(bx + $urandom_range(0, 4095)), 16'(by + $urandom_range(0, 4095)),
                     16'(bz + $urandom_range(0, 4095)), i + 1 == n);
      else
        add_particle(16'($urandom), 16'($urandom), 16'($urandom), i + 1 == n);
    end
  endtask

  // Random register setting, extremes mixed in.
  task automatic random_config();
    write_reg(pdh_pkg::RegBoxXx,
              ($urandom_range(0, 7) == 0) ? 32'hFFFFF : $urandom_range(256, 8192));
    write_reg(pdh_pkg::RegBoxXy,
              ($urandom_range(0, 7) == 0) ? 32'h80000 : $urandom_range(0, 2047) - 1024);
    write_reg(pdh_pkg::RegBoxXz,
              ($urandom_range(0, 7) == 0) ? 32'h7FFFF : $urandom_range(0, 2047) - 1024);
    write_reg(pdh_pkg::RegBoxYy,
              ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom_range(256, 8192));
    write_reg(pdh_pkg::RegBoxYz, $urandom_range(0, 2047) - 1024);
    write_reg(pdh_pkg::RegBoxZz, $urandom_range(256, 8192));
    write_reg(pdh_pkg::RegInvBw,
              ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 1 << 18));
    write_reg(pdh_pkg::RegBins, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(1, 64));
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.frac_x = '0;
    in_if.frac_y = '0;
    in_if.frac_z = '0;
    in_if.last_particle = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = pdh_pkg::RegBoxXx;
    cfg_if.data = '0;
    errors = 0;
    frames_done = 0;
    bins_seen = 0;
    particles_sent = 0;
    holds_asked = 0;
    holds_served = 0;
    hold_left = 0;
    hold_source = 0;
    in_taken = 0;
    idle_cycles = 0;
    stored_n = 0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    for (int i = 0; i < NumBins; i++) hist[i] = 0;
    shadow_cfg.xx = 20'd2560;
    shadow_cfg.xy = '0;
    shadow_cfg.xz = '0;
    shadow_cfg.yy = 20'd2560;
    shadow_cfg.yz = '0;
    shadow_cfg.zz = 20'd2560;
    shadow_cfg.inv_bw_sq = 32'd65536;
    shadow_cfg.nbins = 7'd64;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at reset settings: a lone particle, which gives an empty-pair
    // frame, then field extremes on a pair and across the wrap boundary.
    add_particle(16'h0000, 16'h0000, 16'h0000, 1'b1);
    add_particle(16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_particle(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    add_particle(16'h0000, 16'h8000, 16'h7FFF, 1'b0);
    add_particle(16'h8000, 16'h0000, 16'hFFFF, 1'b0);
    add_particle(16'h7FFF, 16'h5555, 16'hAAAA, 1'b0);
    add_particle(16'h0001, 16'h0001, 16'h0000, 1'b1);
    drain();

    // Smallest bin count, zero bins acting as one and too many acting as the
    // maximum, with the tilt registers at their extremes.
    write_reg(pdh_pkg::RegBins, 32'd1);
    write_reg(pdh_pkg::RegInvBw, 32'hFFFFFFFF);
    add_frame(4, 1'b1);
    drain();
    write_reg(pdh_pkg::RegBins, 32'd0);
    write_reg(pdh_pkg::RegBoxXy, 32'h7FFFF);
    write_reg(pdh_pkg::RegBoxXz, 32'h80000);
    write_reg(pdh_pkg::RegBoxYz, 32'h7FFFF);
    add_frame(3, 1'b0);
    drain();
    write_reg(pdh_pkg::RegBins, 32'd127);
    write_reg(pdh_pkg::RegBoxXx, 32'hFFFFF);
    write_reg(pdh_pkg::RegBoxYy, 32'h0);
    write_reg(pdh_pkg::RegBoxZz, 32'hFFFFF);
    write_reg(pdh_pkg::RegInvBw, 32'h0);
    add_frame(4, 1'b0);
    drain();

    // Long receiver hold-off while the next frame is already offered, so the
    // block backs up and holds its input.
    random_config();
    holds_asked++;
    add_frame(4, 1'b1);
    add_frame(3, 1'b0);
    drain();

    // Random frames with random settings between them; most are small.
    while (particles_sent < ItemTarget - 15) begin
      random_config();
      repeat ($urandom_range(1, 4))
        add_frame($urandom_range(2, 12), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) begin
        holds_asked++;
        add_frame($urandom_range(2, 5), 1'b1);
        add_frame($urandom_range(2, 5), 1'b0);
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("Run covered %0d particle beats and %0d frames, %0d bin beats checked.",
             particles_sent, frames_done, bins_seen);
    if (errors == 0 && bins_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (bins_expected.size() != 0)
        $display("%0d expected bin beats never arrived", bins_expected.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+src
src/pdh_pkg.sv
src/pdh_if.sv
src/pdh_isqrt.sv
src/pdh_dist.sv
src/pair_distance_histogram.sv
tb/tb_pair_distance_histogram.sv
